// ===== rtl/threshold_morph_close_macros.svh =====
// Assertion macros used by the threshold/closing top level.
`ifndef THRESHOLD_MORPH_CLOSE_MACROS_SVH
`define THRESHOLD_MORPH_CLOSE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TMC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("threshold_morph_close: assertion failed");

// Next-cycle implication, checked outside reset
`define TMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("threshold_morph_close: assertion failed");

`endif

// ===== rtl/tmc_pkg.sv =====
// Shared types and constants of the threshold and 3x3 closing block.
package tmc_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 128;
  localparam int COL_W        = $clog2(FRAME_WIDTH);
  localparam int ROW_W        = $clog2(FRAME_HEIGHT);
  localparam int LEVEL_W      = 16;
  localparam int OUT_W        = 7;

  // Line store entry: two dilated rows of column x-1, two binary rows of column x
  localparam int ENTRY_W      = 4;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  localparam col_t COL_LAST = COL_W'(FRAME_WIDTH - 1);
  localparam row_t ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);
  localparam col_t COL_TWO  = COL_W'(2);
  localparam row_t ROW_TWO  = ROW_W'(2);
  localparam col_t COL_FOUR = COL_W'(4);
  localparam row_t ROW_FOUR = ROW_W'(4);

  localparam logic [LEVEL_W-1:0] THRESH_RESET = LEVEL_W'(4096);

  // Input transfer payload
  typedef struct packed {
    logic [LEVEL_W-1:0] activity_level;
    logic               frame_start;
  } tmc_in_t;

  // Output transfer payload
  typedef struct packed {
    logic             closed_pixel;
    logic [OUT_W-1:0] out_x;
    logic [OUT_W-1:0] out_y;
    logic             frame_done;
  } tmc_out_t;

  // One thresholded pixel with its raster position
  typedef struct packed {
    logic bin;
    col_t col;
    row_t row;
  } tmc_pix_t;

  function automatic logic [OUT_W-1:0] col_to_out(input col_t c);
    return OUT_W'(c);
  endfunction

  function automatic logic [OUT_W-1:0] row_to_out(input row_t r);
    return OUT_W'(r);
  endfunction

endpackage

// ===== rtl/threshold_morph_close.sv =====
// Top level: binary threshold followed by a streaming 3x3 morphological closing.
//
// Pixels enter in raster order, one transfer per clock unless stalled, and
// each is compared with the activity threshold. The block sustains one pixel
// per cycle unless the output stalls: the result for (x, y) is registered
// once pixel (x+2, y+2) completes its 5x5 support, and only interior pixels
// (x and y in 2 to size-3) produce a result. All history lives in one line
// store of FRAME_WIDTH x 4 bits (two binary rows and two dilated rows per
// column) read when a pixel is taken and written back when the window stage
// retires it; a bypass covers a back-to-back pair at the same column. The
// store needs no clearing pass after reset. frame_start restarts the raster
// at (0,0). The threshold register sits at byte address 0 of the APB port.
`include "threshold_morph_close_macros.svh"

module threshold_morph_close (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tmc_pkg::tmc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tmc_pkg::tmc_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_THRESHOLD = 1'b0;

  logic [tmc_pkg::LEVEL_W-1:0] thresh_q;
  tmc_pkg::col_t               col_q, col_d, cur_col;
  tmc_pkg::row_t               row_q, row_d, cur_row;
  logic                        in_acc, cfg_wr;
  tmc_pkg::tmc_pix_t           pix;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD);
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'b0, thresh_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= tmc_pkg::THRESH_RESET;
    end else if (cfg_wr) begin
      thresh_q <= pwdata[tmc_pkg::LEVEL_W-1:0];
    end
  end

  // Raster position
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    cur_col = in_data_i.frame_start ? '0 : col_q;
    cur_row = in_data_i.frame_start ? '0 : row_q;
    col_d   = cur_col + 1'b1;
    row_d   = cur_row;
    if (cur_col == tmc_pkg::COL_LAST) begin
      col_d = '0;
      row_d = (cur_row == tmc_pkg::ROW_LAST) ? '0 : cur_row + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Threshold compare
  assign pix.bin = in_data_i.activity_level >= thresh_q;
  assign pix.col = cur_col;
  assign pix.row = cur_row;

  tmc_line_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (in_valid_i),
    .pix_i       (pix),
    .pix_stall_o (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Checks
  `TMC_ASSERT_NOW(a_stall_from_out, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `TMC_ASSERT_NEXT(a_start_col, clk_i, rst_ni, in_acc && in_data_i.frame_start, col_q == tmc_pkg::col_t'(1))
  `TMC_ASSERT_NOW(a_interior, clk_i, rst_ni, out_valid_o, (out_data_o.out_x >= 7'd2) && (out_data_o.out_y >= 7'd2))

endmodule

// ===== rtl/tmc_line_core.sv =====
// Line store, dilation/erosion window stage and output register.
module tmc_line_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_valid_i,
  input  tmc_pkg::tmc_pix_t pix_i,
  output logic             pix_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tmc_pkg::tmc_out_t out_data_o
);

  // Line store, one entry per column
  logic [tmc_pkg::ENTRY_W-1:0] mem [tmc_pkg::FRAME_WIDTH];
  logic [tmc_pkg::ENTRY_W-1:0] rd_q;
  logic [tmc_pkg::ENTRY_W-1:0] fwd_data_q;
  logic                        fwd_q;

  // Window stage
  logic              s1_valid_q;
  tmc_pkg::tmc_pix_t s1_q;
  logic              v1_q, v2_q;   // vertical ORs of columns x-1, x-2
  logic              a1_q, a2_q;   // vertical ANDs of dilated columns x-2, x-3

  // Output register
  logic              out_valid_q, out_valid_d;
  tmc_pkg::tmc_out_t out_q;

  logic                        s1_res, s1_go, out_free, pix_acc;
  logic [tmc_pkg::ENTRY_W-1:0] entry, wd;
  logic                        vcol, dnew, acol, closed;

  // Flow control
  assign s1_res      = (s1_q.col >= tmc_pkg::COL_FOUR) && (s1_q.row >= tmc_pkg::ROW_FOUR);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_go       = s1_valid_q && (!s1_res || out_free);
  assign pix_stall_o = s1_valid_q && !s1_go;
  assign pix_acc     = pix_valid_i && !pix_stall_o;

  // Entry bits: [3] dil(x-1,y-2) [2] dil(x-1,y-3) [1] bin(x,y-1) [0] bin(x,y-2)
  always_comb begin
    entry  = fwd_q ? fwd_data_q : rd_q;
    vcol   = s1_q.bin | entry[1] | entry[0];
    dnew   = vcol | v1_q | v2_q;            // dilation at (x-1, y-1)
    acol   = dnew & entry[3] & entry[2];    // erosion column x-1, rows y-3..y-1
    closed = acol & a1_q & a2_q;            // closed value at (x-2, y-2)
    wd     = {dnew, entry[3], s1_q.bin, entry[1]};
  end

  // Read at accept, write back when the window stage retires
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      mem[s1_q.col] <= wd;
    end
    if (pix_acc) begin
      rd_q       <= mem[pix_i.col];
      fwd_q      <= s1_go && (s1_q.col == pix_i.col);
      fwd_data_q <= wd;
      s1_q       <= pix_i;
    end
  end

  // Horizontal window taps
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      v1_q <= vcol;
      v2_q <= v1_q;
      a1_q <= acol;
      a2_q <= a1_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go && s1_res) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pix_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s1_go && s1_res) begin
      out_q.closed_pixel <= closed;
      out_q.out_x        <= tmc_pkg::col_to_out(s1_q.col - tmc_pkg::COL_TWO);
      out_q.out_y        <= tmc_pkg::row_to_out(s1_q.row - tmc_pkg::ROW_TWO);
      out_q.frame_done   <= (s1_q.col == tmc_pkg::COL_LAST) &&
                            (s1_q.row == tmc_pkg::ROW_LAST);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/closing_checker.sv =====
// Threshold and 3x3 closing checker: predicts and compares every result, checks readback.
`timescale 1ns / 1ps

module closing_checker #(
  parameter logic [2:0] THRESH_ADDR = 3'd0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  tmc_pkg::tmc_in_t    in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  tmc_pkg::tmc_out_t   out_data_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int unsigned         err_count_o,
  output int unsigned         pending_o
);

  import tmc_pkg::*;

  // Five rows of thresholded pixels cover the 5x5 support of one result
  localparam int unsigned ROW_RING = 5;

  bit [FRAME_WIDTH-1:0] bin_rows [ROW_RING];
  int unsigned          col_pos;
  int unsigned          row_pos;
  logic [LEVEL_W-1:0]   level_thr;
  tmc_out_t             closed_q[$];
  int unsigned          mismatches;

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    tmc_out_t    want;
    int unsigned cx;
    int unsigned cy;
    bit          dil;
    bit          acc;
    if (!rst_ni) begin
      for (int r = 0; r < ROW_RING; r++) bin_rows[r] = '0;
      col_pos    = 0;
      row_pos    = 0;
      level_thr  = THRESH_RESET;
      mismatches = 0;
      closed_q.delete();
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready && paddr == THRESH_ADDR) begin
        if (pwrite) level_thr = pwdata[LEVEL_W-1:0];
        else flag("threshold readback", 32'(level_thr), prdata);
      end

      // input transfer: threshold the pixel, predict the pixel whose support it completes
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.frame_start) begin
          col_pos = 0;
          row_pos = 0;
        end
        bin_rows[row_pos % ROW_RING][col_pos] = (in_data_i.activity_level >= level_thr);
        if (col_pos >= 4 && row_pos >= 4) begin
          cx  = col_pos - 2;
          cy  = row_pos - 2;
          // erosion over the 3x3 neighborhood of 3x3 dilations
          acc = 1'b1;
          for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
              dil = 1'b0;
              for (int ey = 0; ey < 3; ey++)
                for (int ex = 0; ex < 3; ex++)
                  dil |= bin_rows[(cy + dy + ey - 2) % ROW_RING][cx + dx + ex - 2];
              acc &= dil;
            end
          end
          want.closed_pixel = acc;
          want.out_x        = OUT_W'(cx);
          want.out_y        = OUT_W'(cy);
          want.frame_done   = (cx == FRAME_WIDTH - 3) && (cy == FRAME_HEIGHT - 3);
          closed_q.push_back(want);
        end
        col_pos++;
        if (col_pos >= FRAME_WIDTH) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= FRAME_HEIGHT) row_pos = 0;
        end
      end

      // output transfer: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (closed_q.size() == 0) begin
          $display("%0t: result with nothing expected, got x=%0d y=%0d pixel=%0d", $time,
                   out_data_i.out_x, out_data_i.out_y, out_data_i.closed_pixel);
          mismatches++;
        end else begin
          want = closed_q.pop_front();
          flag("closed_pixel", 32'(want.closed_pixel), 32'(out_data_i.closed_pixel));
          flag("out_x", 32'(want.out_x), 32'(out_data_i.out_x));
          flag("out_y", 32'(want.out_y), 32'(out_data_i.out_y));
          flag("frame_done", 32'(want.frame_done), 32'(out_data_i.frame_done));
        end
      end
    end
    err_count_o <= mismatches;
    pending_o   <= closed_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: stimulus, register writes and verdict for the threshold and closing block.
`timescale 1ns / 1ps

module tb_top;

  import tmc_pkg::*;

  localparam logic [2:0] THRESH_ADDR = 3'd0;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid;
  tmc_in_t     in_data;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tmc_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned err_count;
  int unsigned pending_results;

  // idling controls for both sides
  bit          src_busy   = 1'b1;
  bit          sink_busy  = 1'b1;
  int unsigned stall_left = 0;

  // directed pixels: field extremes, threshold edges, mid-frame restart
  tmc_in_t directed_px [18] = '{
    '{16'd0,     1'b1}, '{16'hFFFF, 1'b0}, '{16'hFF00, 1'b0}, '{16'd4095,  1'b0},
    '{16'd4096,  1'b0}, '{16'd4097,  1'b0}, '{16'd1,     1'b0}, '{16'h8000, 1'b0},
    '{16'h7FFF,  1'b0}, '{16'h00FF,  1'b0}, '{16'h5555,  1'b0}, '{16'hAAAA, 1'b0},
    '{16'd4096,  1'b1}, '{16'd0,     1'b0}, '{16'hFFFF,  1'b0}, '{16'd4095, 1'b0},
    '{16'hFF01,  1'b0}, '{16'd4096,  1'b0}
  };

  always #6 clk_i = ~clk_i;

  threshold_morph_close i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  closing_checker #(.THRESH_ADDR(THRESH_ADDR)) i_closing_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .err_count_o (err_count),
    .pending_o   (pending_results)
  );

  // receiver stall: mostly short bursts, a few long ones
  always @(posedge clk_i) begin : sink_stall
    int unsigned r;
    if (stall_left != 0) begin
      stall_left--;
    end else if (!sink_busy) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else if (r < 93) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(5, 25);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!src_busy || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // level that lands above or below the threshold with the given odds, plus some noise
  function automatic logic [15:0] pick_level(input logic [15:0] thr, input int unsigned density);
    if ($urandom_range(0, 19) == 0) return 16'($urandom);
    if ($urandom_range(0, 99) < density) return 16'($urandom_range(32'(thr), 32'hFFFF));
    if (thr == 16'd0) return 16'($urandom);
    return 16'($urandom_range(0, 32'(thr) - 1));
  endfunction

  // one pixel transfer, with an optional gap before it; valid stays high afterwards
  task automatic push_pixel(input tmc_in_t px);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and wait until every predicted result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // idle point for register writes: also let pixels with no result leave the pipe
  task automatic settle();
    drain();
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [15:0] thr);
    apb_access(1'b1, THRESH_ADDR, 32'(thr));
    apb_access(1'b0, THRESH_ADDR, '0);
  endtask

  initial begin : stimulus
    int unsigned density;
    int unsigned n_px;
    int unsigned pause_at;
    int unsigned wait_cnt;
    logic [15:0] thr;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    density  = 50;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value readback, then directed pixels at the reset threshold
    apb_access(1'b0, THRESH_ADDR, '0);
    foreach (directed_px[i]) push_pixel(directed_px[i]);
    settle();

    // threshold sweep over short partial frames that stop before the first result row
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       thr = 16'd0;
        1:       thr = 16'hFFFF;
        2:       thr = 16'hFF00;
        default: thr = 16'($urandom_range(32'h0100, 32'hC000));
      endcase
      set_threshold(thr);
      src_busy  = ($urandom_range(0, 3) != 0);
      sink_busy = ($urandom_range(0, 3) != 0);
      n_px      = $urandom_range(120, 200);
      for (int i = 0; i < n_px; i++) begin
        if (i % 32 == 0) density = $urandom_range(0, 100);
        push_pixel('{activity_level: pick_level(thr, density),
                     frame_start: (i == 0) || ($urandom_range(0, 599) == 0)});
      end
      settle();
    end

    // nine rows of a fresh frame: the last five give interior results
    thr = 16'($urandom_range(32'h0800, 32'h8000));
    set_threshold(thr);
    pause_at = $urandom_range(600, 1100);
    for (int i = 0; i < 9 * FRAME_WIDTH; i++) begin
      if (i % 256 == 0) begin
        src_busy  = ($urandom_range(0, 2) == 0);
        sink_busy = ($urandom_range(0, 2) == 0);
      end
      if (i % 32 == 0) density = $urandom_range(0, 100);
      if (i == pause_at) drain();
      push_pixel('{activity_level: pick_level(thr, density), frame_start: (i == 0)});
    end

    // wait out the last results, bounded
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait_cnt = 0;
    while (pending_results != 0 && wait_cnt < 50000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && pending_results == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #25ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== threshold_morph_close.f =====
+incdir+rtl
rtl/tmc_pkg.sv
rtl/tmc_line_core.sv
rtl/threshold_morph_close.sv
tb/closing_checker.sv
tb/tb_top.sv
